>>> rtl/sfae_pkg.sv
// ----------------------------------------------------------------------------
// sfae_pkg
// Types and constants shared by the servo feedback angle estimator modules.
// ----------------------------------------------------------------------------
package sfae_pkg;

    // Register indexes of the configuration port.
    localparam logic [3:0] CFG_ALPHA     = 4'd0;
    localparam logic [3:0] CFG_LEFT_MIN  = 4'd1;
    localparam logic [3:0] CFG_LEFT_MID  = 4'd2;
    localparam logic [3:0] CFG_LEFT_MAX  = 4'd3;
    localparam logic [3:0] CFG_RIGHT_MIN = 4'd4;
    localparam logic [3:0] CFG_RIGHT_MID = 4'd5;
    localparam logic [3:0] CFG_RIGHT_MAX = 4'd6;
    localparam logic [3:0] CFG_MAX_ANGLE = 4'd7;

    // Reset values of the registers.
    localparam logic [15:0] ALPHA_RESET     = 16'd20016;
    localparam logic [11:0] ADC_MIN_RESET   = 12'd0;
    localparam logic [11:0] ADC_MID_RESET   = 12'd2048;
    localparam logic [11:0] ADC_MAX_RESET   = 12'd4095;
    localparam logic [14:0] MAX_ANGLE_RESET = 15'd4000;

    // Angle saturation limit in centidegrees.
    localparam logic signed [35:0] ANGLE_LIMIT = 36'sd18000;

    // Divider widths: dividend and divisor.
    localparam int DVD_W = 34;
    localparam int DEN_W = 18;

    typedef struct packed {
        logic        servo_side;
        logic [11:0] adc_sample;
        logic        sample_missing;
    } in_t;

    typedef struct packed {
        logic               result_side;
        logic [15:0]        filtered_feedback;
        logic signed [15:0] servo_angle;
        logic               range_fault;
    } out_t;

    // Queue entry: the input item plus its classification.
    typedef struct packed {
        in_t  item;
        logic side_ok;
    } entry_t;

    // Calibration set, index 0 left, 1 right.
    typedef struct packed {
        logic [15:0]      alpha;
        logic [1:0][11:0] adc_min;
        logic [1:0][11:0] adc_mid;
        logic [1:0][11:0] adc_max;
        logic [14:0]      max_angle;
    } cfg_t;

endpackage

>>> rtl/servo_feedback_angle_estimator.sv
// ----------------------------------------------------------------------------
// servo_feedback_angle_estimator
// Low-pass filter and two-segment calibration for servo feedback readings.
// ----------------------------------------------------------------------------
// Input items arrive on s_valid/s_ready/s_data, one feedback reading each,
// and every item yields exactly one result on m_valid/m_ready/m_data.
// Items pass a two-entry queue to a back end that handles one at a time.
// A valid reading passes the 34-step serial divider of the angle mapping
// on its way to the output register; a missing reading or a zero segment
// span skips the divider. The back end takes the next item from the queue
// only once the last result has entered the output register.
// Calibration registers are written on cfg_valid/cfg_ready with cfg_index
// and cfg_data; cfg_ready is always high, and writes must be made while
// idle; the block itself does not enforce this. Reset clears both filter
// states, the queue and the output valid flag and loads the calibration
// defaults. When the receiver stalls, the result holds in the output
// register, the back end waits, and the queue keeps accepting transfers
// until it is full.
// ----------------------------------------------------------------------------
module servo_feedback_angle_estimator
    import sfae_pkg::*;
#(
    parameter int SERVO_COUNT = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t   cfg_reg;
    logic   q_valid, q_ready;
    entry_t q_data;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha      <= ALPHA_RESET;
            cfg_reg.adc_min[0] <= ADC_MIN_RESET;
            cfg_reg.adc_mid[0] <= ADC_MID_RESET;
            cfg_reg.adc_max[0] <= ADC_MAX_RESET;
            cfg_reg.adc_min[1] <= ADC_MIN_RESET;
            cfg_reg.adc_mid[1] <= ADC_MID_RESET;
            cfg_reg.adc_max[1] <= ADC_MAX_RESET;
            cfg_reg.max_angle  <= MAX_ANGLE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ALPHA:     cfg_reg.alpha      <= cfg_data;
                CFG_LEFT_MIN:  cfg_reg.adc_min[0] <= cfg_data[11:0];
                CFG_LEFT_MID:  cfg_reg.adc_mid[0] <= cfg_data[11:0];
                CFG_LEFT_MAX:  cfg_reg.adc_max[0] <= cfg_data[11:0];
                CFG_RIGHT_MIN: cfg_reg.adc_min[1] <= cfg_data[11:0];
                CFG_RIGHT_MID: cfg_reg.adc_mid[1] <= cfg_data[11:0];
                CFG_RIGHT_MAX: cfg_reg.adc_max[1] <= cfg_data[11:0];
                CFG_MAX_ANGLE: cfg_reg.max_angle  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    sfae_front #(
        .SERVO_COUNT(SERVO_COUNT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    sfae_back #(
        .SERVO_COUNT(SERVO_COUNT)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/sfae_front.sv
// ----------------------------------------------------------------------------
// sfae_front
// Accepts input items, checks the servo index and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sfae_front
    import sfae_pkg::*;
#(
    parameter int SERVO_COUNT = 2
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  in_t    s_data,
    output logic   q_valid,
    input  logic   q_ready,
    output entry_t q_data
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    entry_t     new_entry;

    // Classify the incoming item.
    always_comb begin
        new_entry.item    = s_data;
        new_entry.side_ok = ({31'd0, s_data.servo_side} < SERVO_COUNT);
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Queue pointers and fill count.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

>>> rtl/sfae_back.sv
// ----------------------------------------------------------------------------
// sfae_back
// Updates the low-pass filter of one servo, maps a valid filtered value to
// an angle with a serial divider and holds the result in an output register.
// ----------------------------------------------------------------------------
module sfae_back
    import sfae_pkg::*;
#(
    parameter int SERVO_COUNT = 2
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   q_valid,
    output logic   q_ready,
    input  entry_t q_data,
    output logic   m_valid,
    input  logic   m_ready,
    output out_t   m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_SEG  = 3'd3;
    localparam logic [2:0] ST_PREP = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [2:0]               state_reg, state_next;
    entry_t                   it_reg;
    logic [27:0]              filt_reg [SERVO_COUNT];
    logic [27:0]              st_cur;
    logic signed [45:0]       prod_reg;
    logic [15:0]              fb_reg;
    logic                     zero_reg;
    logic                     fault_reg;
    logic                     base_reg;
    logic signed [33:0]       num_reg;
    logic signed [17:0]       span_reg;
    logic                     neg_reg;
    logic [DVD_W-1:0]         dvd_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W:0]           rem_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     out_valid_reg;
    out_t                     out_reg;

    logic signed [28:0]       diff;
    logic signed [45:0]       rnd;
    logic signed [30:0]       new_sum;
    logic [27:0]              st_new;
    logic [27:0]              st_use;
    logic [28:0]              fb_sum;
    logic [15:0]              fb_val;
    logic                     upd_en;
    logic [11:0]              mn, md, mx;
    logic [15:0]              mn16, md16, mx16;
    logic                     lower;
    logic signed [17:0]       seg_d, seg_span;
    logic [33:0]              un;
    logic [DEN_W-1:0]         ud;
    logic [DEN_W:0]           rem_sh;
    logic [DEN_W:0]           rem_sub;
    logic signed [35:0]       q_s, ang_s;
    logic signed [15:0]       ang_sat;
    logic                     out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign q_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // Filter state of the current servo.
    always_comb begin
        st_cur = 28'd0;
        for (int i = 0; i < SERVO_COUNT; i++) begin
            if ({31'd0, it_reg.item.servo_side} == i) begin
                st_cur = filt_reg[i];
            end
        end
    end

    // Filter step: error times gain, then rounded update.
    always_comb begin
        diff    = $signed({1'b0, it_reg.item.adc_sample, 16'd0}) - $signed({1'b0, st_cur});
        rnd     = prod_reg + 46'sd32768;
        new_sum = $signed({3'd0, st_cur}) + $signed(rnd[45:16]);
        st_new  = new_sum[30] ? 28'd0 : new_sum[27:0];
        upd_en  = it_reg.side_ok && !it_reg.item.sample_missing;
        st_use  = upd_en ? st_new : st_cur;
        fb_sum  = {1'b0, st_use} + 29'd2048;
        if (!it_reg.side_ok) begin
            fb_val = 16'd0;
        end else if (fb_sum[28]) begin
            fb_val = 16'hFFFF;
        end else begin
            fb_val = fb_sum[27:12];
        end
    end

    // Segment selection.
    always_comb begin
        mn       = cfg.adc_min[it_reg.item.servo_side];
        md       = cfg.adc_mid[it_reg.item.servo_side];
        mx       = cfg.adc_max[it_reg.item.servo_side];
        mn16     = {mn, 4'd0};
        md16     = {md, 4'd0};
        mx16     = {mx, 4'd0};
        lower    = ((fb_reg < md16) == (mn16 < mx16));
        if (lower) begin
            seg_d    = $signed({2'd0, fb_reg}) - $signed({2'd0, mn16});
            seg_span = $signed({2'd0, md16}) - $signed({2'd0, mn16});
        end else begin
            seg_d    = $signed({2'd0, fb_reg}) - $signed({2'd0, md16});
            seg_span = $signed({2'd0, mx16}) - $signed({2'd0, md16});
        end
    end

    // Divider operands and one restoring step.
    always_comb begin
        un      = num_reg[33] ? 34'(-num_reg) : 34'(num_reg);
        ud      = span_reg[17] ? 18'(-span_reg) : 18'(span_reg);
        rem_sh  = {rem_reg[DEN_W-1:0], dvd_reg[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    // Final angle: sign, offset and saturation.
    always_comb begin
        q_s   = neg_reg ? -$signed({2'd0, dvd_reg}) : $signed({2'd0, dvd_reg});
        ang_s = base_reg ? q_s - $signed({21'd0, cfg.max_angle}) : q_s;
        if (zero_reg || fault_reg) begin
            ang_sat = 16'sd0;
        end else if (ang_s > ANGLE_LIMIT) begin
            ang_sat = 16'(ANGLE_LIMIT);
        end else if (ang_s < -ANGLE_LIMIT) begin
            ang_sat = 16'(-ANGLE_LIMIT);
        end else begin
            ang_sat = ang_s[15:0];
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_UPD;
            ST_UPD:  state_next = upd_en ? ST_SEG : ST_FIN;
            ST_SEG:  state_next = (seg_span == 18'sd0) ? ST_FIN : ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == CNT_W'(1)) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Filter state per servo.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SERVO_COUNT; i++) begin
                filt_reg[i] <= 28'd0;
            end
        end else if (state_reg == ST_UPD && upd_en) begin
            for (int i = 0; i < SERVO_COUNT; i++) begin
                if ({31'd0, it_reg.item.servo_side} == i) begin
                    filt_reg[i] <= st_new;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                it_reg    <= q_data;
                fault_reg <= 1'b0;
                zero_reg  <= 1'b1;
            end
            ST_MUL: begin
                prod_reg <= diff * $signed({1'b0, cfg.alpha});
            end
            ST_UPD: begin
                fb_reg   <= fb_val;
                zero_reg <= !upd_en;
            end
            ST_SEG: begin
                num_reg   <= seg_d * $signed({1'b0, cfg.max_angle});
                span_reg  <= seg_span;
                base_reg  <= lower;
                fault_reg <= (seg_span == 18'sd0);
            end
            ST_PREP: begin
                neg_reg <= num_reg[33] ^ span_reg[17];
                dvd_reg <= {un[DVD_W-2:0], 1'b0} + {{(DVD_W-DEN_W){1'b0}}, ud};
                den_reg <= {ud[DEN_W-2:0], 1'b0};
                rem_reg <= '0;
                cnt_reg <= CNT_W'(DVD_W);
            end
            ST_DIV: begin
                if (rem_sub[DEN_W]) begin
                    rem_reg <= rem_sh;
                    dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                end else begin
                    rem_reg <= rem_sub;
                    dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ST_FIN: begin
                if (out_free) begin
                    out_reg.result_side       <= it_reg.item.servo_side;
                    out_reg.filtered_feedback <= fb_reg;
                    out_reg.servo_angle       <= ang_sat;
                    out_reg.range_fault       <= fault_reg;
                end
            end
            default: begin
                zero_reg <= 1'b1;
            end
        endcase
    end

    // Output register valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/sfae_checker.sv
// ----------------------------------------------------------------------------
// sfae_checker
// Port-level checks of the servo feedback angle estimator.
// ----------------------------------------------------------------------------
module sfae_checker
    import sfae_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // A stalled result stays in place.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No result right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The angle stays within the saturation limit.
    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.servo_angle <= 16'sd18000)
                 && (m_data.servo_angle >= -16'sd18000))
        else $error("angle outside limit");

    // A range fault always comes with a zero angle.
    a_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.range_fault |-> m_data.servo_angle == 16'sd0)
        else $error("range fault with nonzero angle");

endmodule

bind servo_feedback_angle_estimator sfae_checker u_sfae_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/tb_servo_feedback_angle_estimator.sv
// ----------------------------------------------------------------------------
// tb_servo_feedback_angle_estimator
// Self-checking bench for the servo feedback angle estimator. A predictor
// tracks both filter states and the calibration set and computes the result
// that each accepted reading should give. Directed tests cover the field
// extremes, missing readings, zero spans, reversed calibration, saturation
// and every register. Random tests follow, with bursts of idling on both
// sides and one long receiver stall.
// ----------------------------------------------------------------------------
module tb_servo_feedback_angle_estimator;
    import sfae_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  SETTLE      = 100;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [15:0] cfg_data;

    // Predictor state: filter values and calibration.
    logic [27:0] filt_state [2];
    logic [15:0] p_alpha;
    logic [11:0] p_min [2];
    logic [11:0] p_mid [2];
    logic [11:0] p_max [2];
    logic [14:0] p_max_angle;

    out_t        angle_expected [$];
    int          error_count;
    int          result_count;
    int          cycle_count;
    bit          idle_enable;
    bit          hold_off;

    servo_feedback_angle_estimator #(.SERVO_COUNT(2)) DUT (.*);

    // Clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("Mismatch at result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        error_count++;
    endtask

    // Division rounded to nearest, halves away from zero.
    function automatic longint round_div(input longint num, input longint den);
        longint un;
        longint ud;
        longint q;
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q  = (un * 2 + ud) / (ud * 2);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    // Filter update and calibration mapping for one reading.
    function automatic out_t predict_angle(input in_t item);
        out_t   r;
        int     s;
        longint st;
        longint diff;
        longint delta;
        longint fb;
        longint mn;
        longint md;
        longint mx;
        longint d;
        longint span;
        longint base;
        longint ang;
        s  = item.servo_side;
        st = filt_state[s];
        r  = '0;
        r.result_side = item.servo_side;
        if (!item.sample_missing) begin
            diff  = (longint'(item.adc_sample) << 16) - st;
            delta = ((diff * p_alpha + (longint'(1) << 48) + 32768) >>> 16)
                    - (longint'(1) << 32);
            st = st + delta;
            if (st < 0) st = 0;
            st = st & 28'hFFFFFFF;
            filt_state[s] = st[27:0];
        end
        fb = (st + 2048) >> 12;
        if (fb > 65535) fb = 65535;
        r.filtered_feedback = fb[15:0];
        if (!item.sample_missing) begin
            mn = longint'(p_min[s]) * 16;
            md = longint'(p_mid[s]) * 16;
            mx = longint'(p_max[s]) * 16;
            if ((fb < md) == (mn < mx)) begin
                d = fb - mn; span = md - mn; base = p_max_angle;
            end else begin
                d = fb - md; span = mx - md; base = 0;
            end
            if (span == 0) begin
                r.range_fault = 1'b1;
            end else begin
                ang = round_div(d * p_max_angle, span) - base;
                if (ang > 18000) ang = 18000;
                if (ang < -18000) ang = -18000;
                r.servo_angle = ang[15:0];
            end
        end
        return r;
    endfunction

    // Random idle burst on the input side, or none.
    task automatic idle_burst();
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // Send one reading and record its expected result at the transfer.
    task automatic send_reading(input logic side, input logic [11:0] adc, input logic miss);
        in_t item;
        item.servo_side     = side;
        item.adc_sample     = adc;
        item.sample_missing = miss;
        idle_burst();
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        angle_expected.push_back(predict_angle(item));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (angle_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Register write while idle; the predictor copy follows it.
    task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ALPHA:     p_alpha     = val;
            CFG_LEFT_MIN:  p_min[0]    = val[11:0];
            CFG_LEFT_MID:  p_mid[0]    = val[11:0];
            CFG_LEFT_MAX:  p_max[0]    = val[11:0];
            CFG_RIGHT_MIN: p_min[1]    = val[11:0];
            CFG_RIGHT_MID: p_mid[1]    = val[11:0];
            CFG_RIGHT_MAX: p_max[1]    = val[11:0];
            CFG_MAX_ANGLE: p_max_angle = val[14:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_calibration(input int side, input logic [11:0] mn,
                                     input logic [11:0] md, input logic [11:0] mx);
        write_reg(side ? CFG_RIGHT_MIN : CFG_LEFT_MIN, {4'hF, mn});
        write_reg(side ? CFG_RIGHT_MID : CFG_LEFT_MID, {4'hA, md});
        write_reg(side ? CFG_RIGHT_MAX : CFG_LEFT_MAX, {4'h5, mx});
    endtask

    // Result checker.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (angle_expected.size() == 0) begin
                report_mismatch("unexpected result, side", m_data.result_side, 0);
            end else begin
                want = angle_expected.pop_front();
                if (m_data.result_side !== want.result_side)
                    report_mismatch("result_side", m_data.result_side, want.result_side);
                if (m_data.filtered_feedback !== want.filtered_feedback)
                    report_mismatch("filtered_feedback", m_data.filtered_feedback,
                                    want.filtered_feedback);
                if (m_data.servo_angle !== want.servo_angle)
                    report_mismatch("servo_angle", m_data.servo_angle, want.servo_angle);
                if (m_data.range_fault !== want.range_fault)
                    report_mismatch("range_fault", m_data.range_fault, want.range_fault);
            end
            result_count++;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                gap = $urandom_range(1, 13);
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic test_defaults();
        send_reading(0, 12'd0, 0);
        send_reading(0, 12'd4095, 0);
        send_reading(1, 12'd4095, 0);
        send_reading(1, 12'd2048, 1);
        send_reading(0, 12'd1234, 1);
        send_reading(1, 12'd0, 0);
        wait_drained();
    endtask

    task automatic test_registers();
        // Full gain makes the filter follow each reading.
        write_reg(CFG_ALPHA, 16'hFFFF);
        write_reg(CFG_MAX_ANGLE, 16'hFFFF);
        write_calibration(0, 12'd4095, 12'd2048, 12'd0);
        write_calibration(1, 12'd100, 12'd100, 12'd3000);
        send_reading(0, 12'd0, 0);
        send_reading(0, 12'd4095, 0);
        send_reading(0, 12'd2048, 0);
        send_reading(1, 12'd50, 0);
        send_reading(1, 12'd4095, 0);
        send_reading(1, 12'd100, 0);
        wait_drained();
        // Zero alpha freezes the filter; all-equal points give zero spans.
        write_reg(CFG_ALPHA, 16'd0);
        write_reg(CFG_MAX_ANGLE, 16'd0);
        write_calibration(0, 12'd0, 12'd0, 12'd0);
        write_calibration(1, 12'hFFF, 12'hFFF, 12'hFFF);
        send_reading(0, 12'd4095, 0);
        send_reading(1, 12'd0, 0);
        send_reading(1, 12'd5, 1);
        wait_drained();
        write_reg(CFG_ALPHA, 16'd1);
        write_reg(CFG_MAX_ANGLE, 16'd18000);
        write_calibration(0, 12'd2000, 12'd2001, 12'd2002);
        write_calibration(1, 12'd0, 12'd2048, 12'd4095);
        send_reading(0, 12'd4095, 0);
        send_reading(1, 12'd4095, 0);
        wait_drained();
    endtask

    task automatic random_calibration();
        int s;
        write_reg(CFG_ALPHA, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(8000, 65535)));
        write_reg(CFG_MAX_ANGLE, ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 18000)));
        for (s = 0; s < 2; s++) begin
            if ($urandom_range(0, 4) == 0)
                write_calibration(s, 12'($urandom), 12'($urandom), 12'($urandom));
            else if ($urandom_range(0, 1) == 0)
                write_calibration(s, 12'($urandom_range(0, 1000)),
                                  12'($urandom_range(1500, 2500)),
                                  12'($urandom_range(3000, 4095)));
            else
                write_calibration(s, 12'($urandom_range(3000, 4095)),
                                  12'($urandom_range(1500, 2500)),
                                  12'($urandom_range(0, 1000)));
        end
    endtask

    task automatic test_random(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_reading(1'($urandom), 12'($urandom), $urandom_range(0, 7) == 0);
    endtask

    // Long receiver stall while readings keep coming.
    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random(20);
        wait_drained();
    endtask

    initial begin
        int phase;
        aresetn = 1'b0; s_valid = 1'b0; s_data = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        error_count = 0; result_count = 0; cycle_count = 0;
        idle_enable = 1'b1; hold_off = 1'b0;
        filt_state[0] = '0; filt_state[1] = '0;
        p_alpha = ALPHA_RESET; p_max_angle = MAX_ANGLE_RESET;
        p_min[0] = ADC_MIN_RESET; p_mid[0] = ADC_MID_RESET; p_max[0] = ADC_MAX_RESET;
        p_min[1] = ADC_MIN_RESET; p_mid[1] = ADC_MID_RESET; p_max[1] = ADC_MAX_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_defaults();
        test_registers();
        test_backpressure();
        for (phase = 0; phase < 8; phase++) begin
            random_calibration();
            test_random(190);
            wait_drained();
        end
        idle_enable = 1'b0;
        test_random(60);
        wait_drained();

        $display("Covered %0d results over directed, register, stall and random phases.",
                 result_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
